@@ src/fjrs_pkg.sv @@
// Shared constants, types and handshake structs of the feeder jam-reverse stepper.
package fjrs_pkg;

  localparam int ANGLE_BITS = 13;
  localparam int RATE_BASE  = 100;
  localparam int RATE_CLAMP = 12;
  localparam int JAM_MULT   = 3;

  localparam int CUR_W  = 16;
  localparam int THR_W  = 14;
  localparam int STEP_W = 13;
  localparam int MOD_W  = 14;
  localparam int RATE_W = 8;
  localparam int MANG_W = 13;
  localparam int INT_W  = 7;
  localparam int JAM_W  = 10;
  localparam int LOCK_W = INT_W + 2;

  localparam int RB_W  = $clog2(RATE_BASE + 1);
  localparam int SUM_W = ((ANGLE_BITS > STEP_W) ? ANGLE_BITS : STEP_W) + 1;
  localparam int DW_A  = (MOD_W > SUM_W) ? MOD_W : SUM_W;
  localparam int DW_B  = (RB_W > RATE_W) ? RB_W : RATE_W;
  localparam int DIV_W = (DW_A > DW_B) ? DW_A : DW_B;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam int IN_BITS  = CUR_W + RATE_W + 1 + MANG_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ANGLE_BITS + 3 + INT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(5000);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(1024);
  localparam logic [MOD_W-1:0]  MOD_RST  = MOD_W'(8192);
  localparam logic [INT_W-1:0]  INT_RST  = INT_W'(RATE_BASE);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JAM_THR = 2'd0,
    REG_STEP    = 2'd1,
    REG_MOD     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OPC_TICK = 1'b0,
    OPC_RATE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    JOB_HOLD,
    JOB_FWD,
    JOB_BACK,
    JOB_LOAD,
    JOB_RATE
  } job_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic phase_b;
    logic save_a;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_b;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ src/fjrs_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all modulo and rate work.
module fjrs_div
  import fjrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o,
  output logic [DIV_W-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    trial   = shifted - {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[DIV_W]) begin
        rem_d = shifted[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end else begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ src/fjrs_datapath.sv @@
// Datapath: configuration registers, feed counters, target state, divider and result register.
module fjrs_datapath
  import fjrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tuser_i,
  input  logic [IN_W-1:0]       s_tdata_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_W-1:0]      m_tdata_o
);

  logic [THR_W-1:0]      thr_q;
  logic [STEP_W-1:0]     step_q;
  logic [MOD_W-1:0]      mod_q;
  logic [ANGLE_BITS-1:0] target_q, target_d;
  logic [INT_W-1:0]      interval_q, interval_d;
  logic [INT_W-1:0]      free_q;
  logic [JAM_W-1:0]      jam_q;
  logic                  firing_q, firing_d;
  job_e                  job_q;
  logic [MANG_W-1:0]     ang_q;
  logic [RATE_W-1:0]     rate_q;
  logic [DIV_W-1:0]      rem_a_q;
  logic                  m_valid_q;
  logic [OUT_W-1:0]      m_data_q;

  logic signed [CUR_W-1:0]  cur;
  logic signed [CUR_W:0]    cur_x;
  logic signed [CUR_W:0]    thr_x;
  logic                     in_band;
  logic                     jammed;
  logic [LOCK_W-1:0]        lock;
  logic signed [JAM_W:0]    neg_lock;
  logic signed [JAM_W:0]    jam_x;
  logic [INT_W-1:0]         free_n;
  logic [JAM_W-1:0]         jam_n;
  logic                     fwd_hit;
  logic                     back_hit;
  logic [RATE_W-1:0]        rate_in;
  logic                     buf_in;
  logic [RATE_W-1:0]        rate_clamped;
  job_e                     job_in;

  logic [MOD_W-1:0]  m_eff;
  logic [SUM_W-1:0]  sum_fwd;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [DIV_W-1:0]  div_rem;
  logic [DIV_W:0]    back_sum;
  logic [DIV_W:0]    back_red;
  logic              fwd_flag;
  logic              back_flag;

  // tick decision
  always_comb begin
    cur      = signed'(s_tdata_i[CUR_W-1:0]);
    cur_x    = (CUR_W+1)'(cur);
    thr_x    = signed'((CUR_W+1)'(thr_q));
    in_band  = (cur_x < thr_x) && (cur_x >= -thr_x);
    jammed   = cur_x > thr_x;
    lock     = LOCK_W'(interval_q) * LOCK_W'(JAM_MULT);
    neg_lock = -signed'((JAM_W+1)'(lock));
    jam_x    = (JAM_W+1)'(signed'(jam_q));
    free_n   = free_q;
    jam_n    = jam_q;
    if (in_band) begin
      if (free_q < interval_q) begin
        free_n = free_q + INT_W'(1);
      end
      jam_n = '1;
    end else if (jammed && (jam_x > neg_lock)) begin
      jam_n = jam_q - JAM_W'(1);
    end
    fwd_hit  = free_n >= interval_q;
    back_hit = !fwd_hit && (signed'((JAM_W+1)'(signed'(jam_n))) <= neg_lock);

    rate_in      = s_tdata_i[CUR_W +: RATE_W];
    buf_in       = s_tdata_i[CUR_W+RATE_W];
    rate_clamped = ((rate_in > RATE_W'(RATE_CLAMP)) && !buf_in) ? RATE_W'(RATE_CLAMP) : rate_in;

    if (s_tuser_i == OPC_TICK) begin
      job_in = fwd_hit ? JOB_FWD : (back_hit ? JOB_BACK : JOB_HOLD);
    end else begin
      job_in = (rate_in == '0) ? JOB_LOAD : JOB_RATE;
    end
  end

  // divider operands
  always_comb begin
    m_eff        = (mod_q == '0) ? (MOD_W'(1) << ANGLE_BITS) : mod_q;
    sum_fwd      = SUM_W'(target_q) + SUM_W'(step_q);
    div_dividend = '0;
    div_divisor  = DIV_W'(m_eff);
    if (cmd_i.phase_b) begin
      div_dividend = DIV_W'(step_q);
    end else begin
      unique case (job_q)
        JOB_FWD:  div_dividend = DIV_W'(sum_fwd);
        JOB_BACK: div_dividend = DIV_W'(target_q);
        JOB_LOAD: div_dividend = DIV_W'(ang_q);
        JOB_RATE: begin
          div_dividend = DIV_W'(RATE_BASE);
          div_divisor  = DIV_W'(rate_q);
        end
        default:  div_dividend = '0;
      endcase
    end
  end

  fjrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // result
  always_comb begin
    back_sum   = {1'b0, rem_a_q} + (DIV_W+1)'(m_eff) - {1'b0, div_rem};
    back_red   = (back_sum >= (DIV_W+1)'(m_eff)) ? back_sum - (DIV_W+1)'(m_eff) : back_sum;
    target_d   = target_q;
    interval_d = interval_q;
    firing_d   = firing_q;
    fwd_flag   = 1'b0;
    back_flag  = 1'b0;
    unique case (job_q)
      JOB_FWD: begin
        target_d = div_rem[ANGLE_BITS-1:0];
        fwd_flag = 1'b1;
      end
      JOB_BACK: begin
        target_d  = back_red[ANGLE_BITS-1:0];
        back_flag = 1'b1;
      end
      JOB_LOAD: begin
        target_d = div_rem[ANGLE_BITS-1:0];
        firing_d = 1'b0;
      end
      JOB_RATE: begin
        interval_d = div_quo[INT_W-1:0];
        firing_d   = 1'b1;
      end
      default: begin
        target_d = target_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THR_RST;
      step_q     <= STEP_RST;
      mod_q      <= MOD_RST;
      target_q   <= '0;
      interval_q <= INT_RST;
      free_q     <= '0;
      jam_q      <= '0;
      firing_q   <= 1'b0;
      job_q      <= JOB_HOLD;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_JAM_THR: thr_q  <= cfg_data_i[THR_W-1:0];
          REG_STEP:    step_q <= cfg_data_i[STEP_W-1:0];
          REG_MOD:     mod_q  <= cfg_data_i[MOD_W-1:0];
          default:     thr_q  <= thr_q;
        endcase
      end
      if (cmd_i.accept) begin
        job_q <= job_in;
        if (s_tuser_i == OPC_TICK) begin
          free_q <= fwd_hit ? '0 : free_n;
          jam_q  <= back_hit ? '1 : jam_n;
        end
      end
      if (cmd_i.commit) begin
        target_q   <= target_d;
        interval_q <= interval_d;
        firing_q   <= firing_d;
        m_valid_q  <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ang_q  <= s_tdata_i[CUR_W+RATE_W+1 +: MANG_W];
      rate_q <= rate_clamped;
    end
    if (cmd_i.save_a) begin
      rem_a_q <= div_rem;
    end
    if (cmd_i.commit) begin
      m_data_q <= OUT_W'({interval_d, firing_d, back_flag, fwd_flag, target_d});
    end
  end

  assign status_o.need_div = job_q != JOB_HOLD;
  assign status_o.need_b   = job_q == JOB_BACK;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !m_valid_q || m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

@@ src/fjrs_ctrl.sv @@
// Controller: sequences accept, divider passes and result hand-off for one item.
module fjrs_ctrl
  import fjrs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_WAIT_A;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WAIT_A: begin
        if (status_i.div_done) begin
          if (status_i.need_b) begin
            cmd_o.save_a    = 1'b1;
            cmd_o.div_start = 1'b1;
            cmd_o.phase_b   = 1'b1;
            state_d         = ST_WAIT_B;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WAIT_B: begin
        if (status_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/feeder_jam_reverse_stepper_unit.sv @@
// Top level of the feeder jam-reverse stepper.
//
// Input channel s_axis: tuser carries the opcode (0 tick, 1 fire rate command),
// tdata the current sample, fire rate, buffer flag and measured angle.
// Output channel m_axis: one result item per input item, in order, carrying the
// target angle, the forward and backward step flags, the firing flag and the
// shot interval.
// Configuration channel cfg: index 0 jam threshold, 1 step size, 2 position
// modulus; always ready, write only while no item is in flight.
// A tick that does not step passes from accept through the launch and done
// states to its result, and the next item is taken back in idle. A forward
// step, an angle load or a rate command adds one pass of the shared
// bit-serial divider, which works out 14 quotient bits; a backward step two
// passes. The block works on one item at a time.
// The result register holds a finished item while the receiver stalls, and
// the block takes the next input item meanwhile; it finishes that item and
// then waits for the register to drain.
// Reset brings back the register defaults, target 0, interval 100, counters
// cleared and firing off; no clearing pass is needed.
module feeder_jam_reverse_stepper_unit
  import fjrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic                  s_axis_tuser,   // opcode
  // motor_current[15:0], fire_rate[23:16], buffer_enabled[24], measured_angle[37:25], zero
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // target_angle[12:0], stepped_forward[13], stepped_back[14], firing_enabled[15],
  // interval_ticks[22:16], zero
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  fjrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fjrs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule
